// ===== rtl/core/prince_block_encrypt_core_macros.svh =====
// Assertion macros for the PRINCE encryption core.
// Needs a clock named clk and a synchronous reset named rst in the including scope.
`ifndef PRINCE_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define PRINCE_BLOCK_ENCRYPT_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PENC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define PENC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/prince_enc_pkg.sv =====
// Constants and layer functions for the PRINCE-64/128 encryption core.
// Self-contained; imported by prince_block_encrypt_core.
package prince_enc_pkg;

  localparam int NumStages = 12;

  // Configuration register indexes
  localparam logic [1:0] RegWhiteningKey = 2'd0;
  localparam logic [1:0] RegCoreKey      = 2'd1;

  localparam logic [3:0] SboxFwd [16] = '{
    4'hB, 4'hF, 4'h3, 4'h2, 4'hA, 4'hC, 4'h9, 4'h1,
    4'h6, 4'h7, 4'h8, 4'h0, 4'hE, 4'h5, 4'hD, 4'h4
  };

  localparam logic [3:0] SboxInv [16] = '{
    4'hB, 4'h7, 4'h3, 4'h2, 4'hF, 4'hD, 4'h8, 4'h9,
    4'hA, 4'h6, 4'h4, 4'h0, 4'h5, 4'hE, 4'hC, 4'h1
  };

  localparam logic [63:0] RoundConst [12] = '{
    64'h0000000000000000, 64'h13198a2e03707344,
    64'ha4093822299f31d0, 64'h082efa98ec4e6c89,
    64'h452821e638d01377, 64'hbe5466cf34e90c6c,
    64'h7ef84f78fd955cb1, 64'h85840851f1ac43aa,
    64'hc882d32f25323c54, 64'h64a51195e0e3610d,
    64'hd3b5a399ca0c2399, 64'hc0ac29b7c97c50dd
  };

  // Output nibble i takes input nibble ShiftSrc[i]; nibble 0 is bits 63..60
  localparam int ShiftSrc [16] = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};

  localparam logic [3:0] DiagMask [4] = '{4'h7, 4'hB, 4'hD, 4'hE};

  function automatic logic [63:0] sub_fwd(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      r[60-4*k +: 4] = SboxFwd[x[60-4*k +: 4]];
    end
    return r;
  endfunction

  function automatic logic [63:0] sub_inv(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      r[60-4*k +: 4] = SboxInv[x[60-4*k +: 4]];
    end
    return r;
  endfunction

  // M' = diag(M0^, M1^, M1^, M0^) over 16-bit chunks, top chunk first
  function automatic logic [63:0] m_prime(input logic [63:0] x);
    logic [63:0] r;
    logic [3:0]  acc;
    int          s;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      s = (c == 0 || c == 3) ? 0 : 1;
      for (int row = 0; row < 4; row++) begin
        acc = '0;
        for (int j = 0; j < 4; j++) begin
          acc ^= DiagMask[2'(row + j + s)] & x[60-4*(4*c+j) +: 4];
        end
        r[60-4*(4*c+row) +: 4] = acc;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] shift_rows(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[60-4*i +: 4] = x[60-4*ShiftSrc[i] +: 4];
    end
    return r;
  endfunction

  function automatic logic [63:0] shift_rows_inv(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[60-4*ShiftSrc[i] +: 4] = x[60-4*i +: 4];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/prince_block_encrypt_core.sv =====
// PRINCE-64/128 encryption core: twelve-stage round pipeline plus output register.
// Depends on prince_enc_pkg and prince_block_encrypt_core_macros.svh.
//
// Usage:
//   Command channel: a block is taken at each rising edge with start high and busy
//   low. busy is held low, so a new plaintext beat can be issued every cycle.
//   Result channel: done pulses for one cycle with ciphertext alongside; the
//   receiver must take it in that cycle, there is no back-pressure.
//   Pipeline: an accepted block passes through the stage registers and then the
//   output register, where done rises with ciphertext (one round per stage:
//   pre-whitening, five forward rounds, middle layer, five inverse rounds, with
//   the last key add and post-whitening ahead of the output register).
//   Throughput: one block per cycle, set by the one-round-per-stage split.
//   Config channel: cfg_valid/cfg_ready (ready held high), cfg_index 0 writes
//   whitening_key (k0), 1 writes core_key (k1); other indexes are dropped.
//   Keys feed all stages but stage 6 live, so write them only with the pipe empty.
//   Reset: rst (synchronous) clears both keys and all stage valid bits; blocks
//   in flight are discarded and no done pulse follows.
`include "prince_block_encrypt_core_macros.svh"

module prince_block_encrypt_core
  import prince_enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plaintext,
  output logic        done,
  output logic [63:0] ciphertext,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] whitening_key;
  logic [63:0] core_key;
  logic [63:0] k0_prime;

  logic [63:0]          stage      [NumStages];
  logic [63:0]          stage_next [NumStages];
  logic [NumStages-1:0] valid;
  logic                 accept;
  logic [63:0]          ciphertext_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      whitening_key <= '0;
      core_key      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegWhiteningKey: whitening_key <= cfg_data;
        RegCoreKey:      core_key      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign k0_prime = {whitening_key[0], whitening_key[63:1]} ^ {63'b0, whitening_key[63]};

  always_comb begin
    stage_next[0] = plaintext ^ whitening_key ^ core_key ^ RoundConst[0];
    for (int i = 1; i <= 5; i++) begin
      stage_next[i] = shift_rows(m_prime(sub_fwd(stage[i-1]))) ^ core_key ^ RoundConst[i];
    end
    stage_next[6] = sub_inv(m_prime(sub_fwd(stage[5])));
    // inverse rounds use RC6..RC10
    for (int i = 7; i < NumStages; i++) begin
      stage_next[i] = sub_inv(m_prime(shift_rows_inv(stage[i-1] ^ core_key ^ RoundConst[i-1])));
    end
    ciphertext_next = stage[NumStages-1] ^ core_key ^ RoundConst[11] ^ k0_prime;
  end

  // datapath: no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < NumStages; i++) begin
      stage[i] <= stage_next[i];
    end
    ciphertext <= ciphertext_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      valid <= {valid[NumStages-2:0], accept};
      done  <= valid[NumStages-1];
    end
  end

  `PENC_ASSERT_IMP(a_latency, accept, ##13 done, "accepted beat not done at the 13th edge")
  `PENC_ASSERT_IMP(a_no_spurious, done, $past(accept, 13), "done without a beat 13 edges earlier")
  `PENC_ASSERT_NXT(a_cfg_taken, cfg_valid && cfg_index == RegCoreKey, core_key == $past(cfg_data), "core key write lost")

endmodule
